// ===== hw/rtl/cssm_pkg.sv =====
package cssm_pkg;

    localparam int IDX_W  = 8;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_SORT   = 2'd2,
        ACT_MEDIAN = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_WR, S_RD, S_RDW, S_CPY, S_CPYW, S_LDV, S_LDW,
        S_CMP, S_CMPW, S_PUT, S_MED, S_MEDW, S_FIN
    } t_state;

    typedef enum logic [2:0] {
        A_LO, A_I, A_J, A_JM1, A_MED
    } t_asel;

    typedef enum logic [1:0] {
        W_VAL, W_RDC, W_RDM, W_V
    } t_wsrc;

    typedef struct packed {
        logic    ld;
        logic    rd;
        logic    we_c;
        logic    we_s;
        t_asel   asel;
        t_wsrc   wsrc;
        logic    i_lo;
        logic    i_lo1;
        logic    i_inc;
        logic    j_ld;
        logic    j_dec;
        logic    v_ld;
        logic    out_ld;
        logic    dsel_rd;
        logic    ok;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    lo_ok;
        logic    rng_ok;
        logic    j_eq_lo;
        logic    i_eq_hi;
        logic    less;
    } t_sts;

endpackage

// ===== hw/rtl/cssm_ctrl.sv =====
module cssm_ctrl
    import cssm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_okf, n_okf;
    logic   r_rdres, n_rdres;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_okf       <= 1'b0;
            r_rdres     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_okf       <= n_okf;
            r_rdres     <= n_rdres;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        t_cmd c;
        logic med;
        c         = '0;
        c.asel    = A_LO;
        c.wsrc    = W_VAL;
        med       = (i_sts.act == ACT_MEDIAN);
        n_state   = r_state;
        n_okf     = r_okf;
        n_rdres   = r_rdres;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    c.ld    = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_okf   = 1'b0;
                n_rdres = 1'b0;
                unique case (i_sts.act)
                    ACT_WRITE: n_state = i_sts.lo_ok ? S_WR : S_FIN;
                    ACT_READ:  n_state = i_sts.lo_ok ? S_RD : S_FIN;
                    ACT_SORT: begin
                        c.i_lo1 = 1'b1;
                        n_state = i_sts.rng_ok ? S_LDV : S_FIN;
                    end
                    ACT_MEDIAN: begin
                        c.i_lo  = 1'b1;
                        n_state = i_sts.rng_ok ? S_CPY : S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_WR: begin
                c.asel  = A_LO;
                c.wsrc  = W_VAL;
                c.we_c  = 1'b1;
                n_okf   = 1'b1;
                n_state = S_FIN;
            end
            S_RD: begin
                c.asel  = A_LO;
                c.rd    = 1'b1;
                n_state = S_RDW;
            end
            S_RDW: begin
                n_okf   = 1'b1;
                n_rdres = 1'b1;
                n_state = S_FIN;
            end
            S_CPY: begin
                c.asel  = A_I;
                c.rd    = 1'b1;
                n_state = S_CPYW;
            end
            S_CPYW: begin
                c.asel = A_I;
                c.wsrc = W_RDC;
                c.we_s = 1'b1;
                if (i_sts.i_eq_hi) begin
                    c.i_lo1 = 1'b1;
                    n_state = S_LDV;
                end else begin
                    c.i_inc = 1'b1;
                    n_state = S_CPY;
                end
            end
            S_LDV: begin
                c.asel  = A_I;
                c.rd    = 1'b1;
                c.j_ld  = 1'b1;
                n_state = S_LDW;
            end
            S_LDW: begin
                c.v_ld  = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.j_eq_lo) begin
                    n_state = S_PUT;
                end else begin
                    c.asel  = A_JM1;
                    c.rd    = 1'b1;
                    n_state = S_CMPW;
                end
            end
            S_CMPW: begin
                if (i_sts.less) begin
                    c.asel  = A_J;
                    c.wsrc  = W_RDM;
                    c.we_c  = !med;
                    c.we_s  = med;
                    c.j_dec = 1'b1;
                    n_state = S_CMP;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                c.asel = A_J;
                c.wsrc = W_V;
                c.we_c = !med;
                c.we_s = med;
                if (i_sts.i_eq_hi) begin
                    n_okf   = 1'b1;
                    n_state = med ? S_MED : S_FIN;
                end else begin
                    c.i_inc = 1'b1;
                    n_state = S_LDV;
                end
            end
            S_MED: begin
                c.asel  = A_MED;
                c.rd    = 1'b1;
                n_state = S_MEDW;
            end
            S_MEDW: begin
                n_rdres = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    c.out_ld    = 1'b1;
                    c.ok        = r_okf;
                    c.dsel_rd   = r_rdres;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd = c;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/cssm_dpath.sv =====
module cssm_dpath
    import cssm_pkg::*;
#(
    parameter int CELL_COUNT = 256
) (
    input  logic                     i_clk,
    input  t_cmd                     i_cmd,
    input  logic [1:0]               i_action,
    input  logic [IDX_W-1:0]         i_index,
    input  logic [IDX_W-1:0]         i_range_end,
    input  logic signed [DATA_W-1:0] i_value,
    output t_sts                     o_sts,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_ok
);

    localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    logic [DATA_W-1:0] r_cells   [CELL_COUNT];
    logic [DATA_W-1:0] r_scratch [CELL_COUNT];

    t_action           r_act;
    logic [IDX_W-1:0]  r_lo, r_hi, r_i, r_j;
    logic [DATA_W-1:0] r_val, r_v, r_rd_c, r_rd_s, r_data;
    logic              r_ok;

    logic [IDX_W-1:0]  w_addr8, w_med;
    logic [AW-1:0]     w_addr;
    logic [DATA_W-1:0] w_wdata, w_rsel;

    assign w_med  = r_lo + ((r_hi - r_lo) >> 1);
    assign w_rsel = (r_act == ACT_MEDIAN) ? r_rd_s : r_rd_c;

    always_comb begin
        unique case (i_cmd.asel)
            A_LO:    w_addr8 = r_lo;
            A_I:     w_addr8 = r_i;
            A_J:     w_addr8 = r_j;
            A_JM1:   w_addr8 = r_j - 1'b1;
            A_MED:   w_addr8 = w_med;
            default: w_addr8 = r_lo;
        endcase
        unique case (i_cmd.wsrc)
            W_VAL:   w_wdata = r_val;
            W_RDC:   w_wdata = r_rd_c;
            W_RDM:   w_wdata = w_rsel;
            W_V:     w_wdata = r_v;
            default: w_wdata = r_val;
        endcase
    end

    assign w_addr = AW'(w_addr8);

    always_ff @(posedge i_clk) begin
        if (i_cmd.we_c) begin
            r_cells[w_addr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_c <= r_cells[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we_s) begin
            r_scratch[w_addr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_s <= r_scratch[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_act <= t_action'(i_action);
            r_lo  <= i_index;
            r_hi  <= i_range_end;
            r_val <= i_value;
        end
        if (i_cmd.i_lo) begin
            r_i <= r_lo;
        end else if (i_cmd.i_lo1) begin
            r_i <= r_lo + 1'b1;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.j_ld) begin
            r_j <= r_i;
        end else if (i_cmd.j_dec) begin
            r_j <= r_j - 1'b1;
        end
        if (i_cmd.v_ld) begin
            r_v <= w_rsel;
        end
        if (i_cmd.out_ld) begin
            r_data <= i_cmd.dsel_rd ? w_rsel : '0;
            r_ok   <= i_cmd.ok;
        end
    end

    assign o_sts.act     = r_act;
    assign o_sts.lo_ok   = (32'(r_lo) < 32'(CELL_COUNT));
    assign o_sts.rng_ok  = (32'(r_hi) < 32'(CELL_COUNT)) && (r_lo < r_hi);
    assign o_sts.j_eq_lo = (r_j == r_lo);
    assign o_sts.i_eq_hi = (r_i == r_hi);
    assign o_sts.less    = ($signed(r_v) < $signed(w_rsel));

    assign o_data = r_data;
    assign o_ok   = r_ok;

endmodule

// ===== hw/rtl/cell_store_sort_median_core.sv =====
// Sort of index..range_end is an insertion sort on the single-port cell memory;
// each compare reads a cell, then checks it against the value being inserted.
// Median: copy the range to scratch memory, sort it there, read the middle cell.
// Flow: one word at a time; the next word is taken once the result is loaded.
// Reset: synchronous, active low; clears control only, cell contents undefined.
module cell_store_sort_median_core
    import cssm_pkg::*;
#(
    parameter int CELL_COUNT = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_action,
    input  logic [IDX_W-1:0]         i_index,
    input  logic [IDX_W-1:0]         i_range_end,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_ok
);

    t_cmd w_cmd;
    t_sts w_sts;

    cssm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cssm_dpath #(
        .CELL_COUNT (CELL_COUNT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_action    (i_action),
        .i_index     (i_index),
        .i_range_end (i_range_end),
        .i_value     (i_value),
        .o_sts       (w_sts),
        .o_data      (o_data),
        .o_ok        (o_ok)
    );

endmodule

// ===== tb/cell_store_sort_median_core_tb.sv =====
`timescale 1ns / 1ps

module cell_store_sort_median_core_tb;
    import cssm_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic                     ok;
    } t_reply;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [1:0]               i_action = ACT_WRITE;
    logic [IDX_W-1:0]         i_index = '0;
    logic [IDX_W-1:0]         i_range_end = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [DATA_W-1:0] o_data;
    logic                     o_ok;

    logic signed [DATA_W-1:0] shadow_cells [256];
    t_reply                   pending_replies [$];
    int                       fail_count = 0;
    bit                       no_gaps = 1'b0;
    int                       out_gap;

    cell_store_sort_median_core dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $signed($urandom_range(0, 15)) - 8;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic sort_shadow(input int lo, input int hi);
        logic signed [DATA_W-1:0] v;
        int j;
        for (int i = lo + 1; i <= hi; i++) begin
            v = shadow_cells[i];
            j = i;
            while (j > lo && v < shadow_cells[j-1]) begin
                shadow_cells[j] = shadow_cells[j-1];
                j--;
            end
            shadow_cells[j] = v;
        end
    endtask

    function automatic logic signed [DATA_W-1:0] median_of(input int lo, input int hi);
        logic signed [DATA_W-1:0] tmp [256];
        logic signed [DATA_W-1:0] v;
        int n;
        int j;
        n = hi - lo + 1;
        for (int i = 0; i < n; i++) tmp[i] = shadow_cells[lo+i];
        for (int i = 1; i < n; i++) begin
            v = tmp[i];
            j = i;
            while (j > 0 && v < tmp[j-1]) begin
                tmp[j] = tmp[j-1];
                j--;
            end
            tmp[j] = v;
        end
        return tmp[(hi - lo) / 2];
    endfunction

    task automatic predict_reply(input t_action act, input int lo, input int hi,
                                 input logic signed [DATA_W-1:0] val);
        t_reply r;
        r = '{data: '0, ok: 1'b0};
        case (act)
            ACT_WRITE: begin
                shadow_cells[lo] = val;
                r.ok = 1'b1;
            end
            ACT_READ: begin
                r.data = shadow_cells[lo];
                r.ok = 1'b1;
            end
            default: begin
                if (lo < hi) begin
                    r.ok = 1'b1;
                    if (act == ACT_SORT) sort_shadow(lo, hi);
                    else r.data = median_of(lo, hi);
                end
            end
        endcase
        pending_replies.push_back(r);
    endtask

    // drive one word and hold it until accepted
    task automatic send_word(input t_action act, input int lo, input int hi,
                             input logic signed [DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_action    = act;
        i_index     = lo[IDX_W-1:0];
        i_range_end = hi[IDX_W-1:0];
        i_value     = val;
        do @(posedge i_clk); while (!o_in_ready);
        predict_reply(act, lo, hi, val);
    endtask

    always begin
        @(negedge i_clk);
        out_gap = pick_gap();
        if (out_gap > 0) begin
            i_out_ready <= 1'b0;
            repeat (out_gap) @(negedge i_clk);
        end
        i_out_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_reply exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected reply data=%0d ok=%0b", o_data, o_ok);
                fail_count++;
            end else begin
                exp_r = pending_replies.pop_front();
                if (o_data !== exp_r.data) begin
                    $error("data: expected %0d actual %0d", exp_r.data, o_data);
                    fail_count++;
                end
                if (o_ok !== exp_r.ok) begin
                    $error("ok: expected %0b actual %0b", exp_r.ok, o_ok);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        for (int i = 0; i < 8; i++) send_word(ACT_WRITE, i, 0, pick_value());
        send_word(ACT_WRITE, 255, 255, 32'sh8000_0000);
        send_word(ACT_WRITE, 254, 0, 32'sh7FFF_FFFF);
        send_word(ACT_READ, 0, 0, 0);
        send_word(ACT_READ, 255, 0, 0);
        send_word(ACT_READ, 254, 0, 0);
        send_word(ACT_MEDIAN, 0, 7, 0);
        send_word(ACT_MEDIAN, 0, 6, 0);
        send_word(ACT_SORT, 0, 7, 0);
        send_word(ACT_READ, 0, 0, 0);
        send_word(ACT_READ, 7, 0, 0);
        send_word(ACT_MEDIAN, 254, 255, 0);
        send_word(ACT_SORT, 254, 255, 0);
        send_word(ACT_READ, 254, 0, 0);
        send_word(ACT_SORT, 5, 5, 0);
        send_word(ACT_MEDIAN, 7, 3, 0);
        send_word(ACT_SORT, 255, 0, 0);
        send_word(ACT_MEDIAN, 0, 0, 0);
    endtask

    task automatic test_fill();
        no_gaps = 1'b1;
        for (int i = 0; i < 128; i++) send_word(ACT_WRITE, i, 0, pick_value());
        no_gaps = 1'b0;
        for (int i = 128; i < 256; i++) send_word(ACT_WRITE, i, 0, pick_value());
    endtask

    task automatic test_random(input int count);
        int lo;
        int hi;
        t_action act;
        for (int k = 0; k < count; k++) begin
            no_gaps = (k % 200) < 30;
            act = t_action'($urandom_range(0, 3));
            lo  = $urandom_range(0, 255);
            if (act == ACT_SORT || act == ACT_MEDIAN) begin
                if ($urandom_range(0, 9) == 0) hi = $urandom_range(0, lo);
                else begin
                    lo = $urandom_range(0, 254);
                    hi = lo + $urandom_range(1, 15);
                    if (hi > 255) hi = 255;
                end
            end else begin
                hi = $urandom_range(0, 255);
            end
            send_word(act, lo, hi, pick_value());
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_full_range();
        send_word(ACT_MEDIAN, 0, 255, 0);
        send_word(ACT_SORT, 0, 255, 0);
        send_word(ACT_MEDIAN, 0, 254, 0);
        send_word(ACT_READ, 128, 0, 0);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_fill();
        test_random(870);
        test_full_range();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
